### rtl/sipnict_pkg.sv
// ----------------------------------------------------------------------------
// sipnict_pkg
// Shared codes, widths and types of the non-INVITE client transaction block.
// ----------------------------------------------------------------------------
package sipnict_pkg;

  localparam int CodeW    = 10;
  localparam int PhaseW   = 3;
  localparam int EvW      = 2;
  localparam int OpW      = 2;
  localparam int MsW      = 16;
  localparam int TimeoutW = 22;
  localparam int CfgAddrW = 2;

  // Timer F runs this many T1 intervals.
  localparam int TIMEOUT_MULTIPLE = 64;
  // Status codes at or above this value are final responses.
  localparam logic [CodeW-1:0] FINAL_CODE_MIN = CodeW'(200);

  // Input operations.
  localparam logic [OpW-1:0] OP_SEND      = 2'd0;
  localparam logic [OpW-1:0] OP_RESPONSE  = 2'd1;
  localparam logic [OpW-1:0] OP_TICK      = 2'd2;
  localparam logic [OpW-1:0] OP_TERMINATE = 2'd3;

  // Transaction phases.
  localparam logic [PhaseW-1:0] PH_IDLE       = 3'd0;
  localparam logic [PhaseW-1:0] PH_TRYING     = 3'd1;
  localparam logic [PhaseW-1:0] PH_PROCEEDING = 3'd2;
  localparam logic [PhaseW-1:0] PH_COMPLETED  = 3'd3;
  localparam logic [PhaseW-1:0] PH_TERMINATED = 3'd4;

  // Result events.
  localparam logic [EvW-1:0] EV_TRANSMIT   = 2'd0;
  localparam logic [EvW-1:0] EV_DELIVER    = 2'd1;
  localparam logic [EvW-1:0] EV_TIMEOUT    = 2'd2;
  localparam logic [EvW-1:0] EV_TERMINATED = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] CFG_BASE_INTERVAL = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_MAX_INTERVAL  = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_LINGER        = 2'd2;
  localparam logic [CfgAddrW-1:0] CFG_RELIABLE      = 2'd3;

  typedef struct packed {
    logic [MsW-1:0] base_interval_ms;
    logic [MsW-1:0] max_interval_ms;
    logic [MsW-1:0] linger_ms;
    logic           reliable_transport;
  } cfg_t;

  typedef struct packed {
    logic [EvW-1:0]    event_res;
    logic [CodeW-1:0]  event_code;
    logic [PhaseW-1:0] phase_now;
    logic              last;
  } result_t;

  // Zero, one or two results caused by one input item.
  typedef struct packed {
    logic    any;
    logic    two;
    result_t r0;
    result_t r1;
  } res_pair_t;

endpackage

### rtl/sipnict_fsm.sv
// ----------------------------------------------------------------------------
// sipnict_fsm
// Transaction state and timers E, F and K; computes the results of one item.
// ----------------------------------------------------------------------------
module sipnict_fsm (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [sipnict_pkg::OpW-1:0]     op,
  input  logic [sipnict_pkg::CodeW-1:0]   status_code,
  input  sipnict_pkg::cfg_t               cfg,
  output sipnict_pkg::res_pair_t          res
);

  logic [sipnict_pkg::PhaseW-1:0]   phase_r, phase_nxt;
  logic [sipnict_pkg::MsW-1:0]      retx_rem_r, retx_rem_nxt;
  logic [sipnict_pkg::MsW-1:0]      retx_int_r, retx_int_nxt;
  logic                             retx_armed_r, retx_armed_nxt;
  logic [sipnict_pkg::TimeoutW-1:0] to_rem_r, to_rem_nxt;
  logic                             to_armed_r, to_armed_nxt;
  logic [sipnict_pkg::MsW-1:0]      lin_rem_r, lin_rem_nxt;
  logic                             lin_armed_r, lin_armed_nxt;

  logic                             f_exp, e_exp, k_exp, active;
  logic [sipnict_pkg::TimeoutW-1:0] to_dec;
  logic [sipnict_pkg::MsW-1:0]      retx_dec, lin_dec, retx_new;
  logic [sipnict_pkg::MsW:0]        retx_dbl;

  // An armed timer expires on the tick where one or less remains; expiry alone does not disarm it.
  assign f_exp  = to_armed_r   && (to_rem_r   <= sipnict_pkg::TimeoutW'(1));
  assign e_exp  = retx_armed_r && (retx_rem_r <= sipnict_pkg::MsW'(1));
  assign k_exp  = lin_armed_r  && (lin_rem_r  <= sipnict_pkg::MsW'(1));
  assign to_dec   = f_exp ? '0 : (to_armed_r   ? to_rem_r   - 1'b1 : to_rem_r);
  assign retx_dec = e_exp ? '0 : (retx_armed_r ? retx_rem_r - 1'b1 : retx_rem_r);
  assign lin_dec  = k_exp ? '0 : (lin_armed_r  ? lin_rem_r  - 1'b1 : lin_rem_r);
  assign active = (phase_r == sipnict_pkg::PH_TRYING) ||
                  (phase_r == sipnict_pkg::PH_PROCEEDING);

  // Retransmit interval doubles up to T2 in trying and jumps to T2 in proceeding.
  assign retx_dbl = {retx_int_r, 1'b0};
  always_comb begin
    if (phase_r != sipnict_pkg::PH_TRYING) begin
      retx_new = cfg.max_interval_ms;
    end else if (retx_dbl < {1'b0, cfg.max_interval_ms}) begin
      retx_new = retx_dbl[sipnict_pkg::MsW-1:0];
    end else begin
      retx_new = cfg.max_interval_ms;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    retx_rem_nxt   = retx_rem_r;
    retx_int_nxt   = retx_int_r;
    retx_armed_nxt = retx_armed_r;
    to_rem_nxt     = to_rem_r;
    to_armed_nxt   = to_armed_r;
    lin_rem_nxt    = lin_rem_r;
    lin_armed_nxt  = lin_armed_r;
    res            = '0;

    unique case (op)
      sipnict_pkg::OP_SEND: begin
        if (phase_r == sipnict_pkg::PH_IDLE) begin
          phase_nxt    = sipnict_pkg::PH_TRYING;
          to_rem_nxt   = sipnict_pkg::TimeoutW'(cfg.base_interval_ms *
                                                 sipnict_pkg::TIMEOUT_MULTIPLE);
          to_armed_nxt = 1'b1;
          if (!cfg.reliable_transport) begin
            retx_int_nxt   = cfg.base_interval_ms;
            retx_rem_nxt   = cfg.base_interval_ms;
            retx_armed_nxt = 1'b1;
          end
          res.any          = 1'b1;
          res.r0.event_res = sipnict_pkg::EV_TRANSMIT;
          res.r0.phase_now = sipnict_pkg::PH_TRYING;
        end
      end
      sipnict_pkg::OP_RESPONSE: begin
        if (active) begin
          res.any           = 1'b1;
          res.r0.event_res  = sipnict_pkg::EV_DELIVER;
          res.r0.event_code = status_code;
          if (status_code < sipnict_pkg::FINAL_CODE_MIN) begin
            phase_nxt        = sipnict_pkg::PH_PROCEEDING;
            res.r0.phase_now = sipnict_pkg::PH_PROCEEDING;
          end else begin
            retx_armed_nxt   = 1'b0;
            retx_rem_nxt     = '0;
            to_armed_nxt     = 1'b0;
            to_rem_nxt       = '0;
            res.r0.phase_now = sipnict_pkg::PH_COMPLETED;
            if (!cfg.reliable_transport) begin
              phase_nxt     = sipnict_pkg::PH_COMPLETED;
              lin_rem_nxt   = cfg.linger_ms;
              lin_armed_nxt = 1'b1;
            end else begin
              phase_nxt        = sipnict_pkg::PH_TERMINATED;
              lin_armed_nxt    = 1'b0;
              lin_rem_nxt      = '0;
              res.two          = 1'b1;
              res.r1.event_res = sipnict_pkg::EV_TERMINATED;
              res.r1.phase_now = sipnict_pkg::PH_TERMINATED;
            end
          end
        end
      end
      sipnict_pkg::OP_TICK: begin
        to_rem_nxt   = to_dec;
        retx_rem_nxt = retx_dec;
        lin_rem_nxt  = lin_dec;
        if (f_exp && active) begin
          // Timer F wins over timer E on the same tick.
          phase_nxt        = sipnict_pkg::PH_TERMINATED;
          retx_armed_nxt   = 1'b0;
          retx_rem_nxt     = '0;
          to_armed_nxt     = 1'b0;
          to_rem_nxt       = '0;
          lin_armed_nxt    = 1'b0;
          lin_rem_nxt      = '0;
          res.any          = 1'b1;
          res.two          = 1'b1;
          res.r0.event_res = sipnict_pkg::EV_TIMEOUT;
          res.r0.phase_now = phase_r;
          res.r1.event_res = sipnict_pkg::EV_TERMINATED;
          res.r1.phase_now = sipnict_pkg::PH_TERMINATED;
        end else if (e_exp && active) begin
          retx_int_nxt     = retx_new;
          retx_rem_nxt     = retx_new;
          res.any          = 1'b1;
          res.r0.event_res = sipnict_pkg::EV_TRANSMIT;
          res.r0.phase_now = phase_r;
        end else if (k_exp && (phase_r == sipnict_pkg::PH_COMPLETED)) begin
          phase_nxt        = sipnict_pkg::PH_TERMINATED;
          retx_armed_nxt   = 1'b0;
          retx_rem_nxt     = '0;
          to_armed_nxt     = 1'b0;
          to_rem_nxt       = '0;
          lin_armed_nxt    = 1'b0;
          lin_rem_nxt      = '0;
          res.any          = 1'b1;
          res.r0.event_res = sipnict_pkg::EV_TERMINATED;
          res.r0.phase_now = sipnict_pkg::PH_TERMINATED;
        end
      end
      sipnict_pkg::OP_TERMINATE: begin
        if (phase_r != sipnict_pkg::PH_TERMINATED) begin
          phase_nxt        = sipnict_pkg::PH_TERMINATED;
          retx_armed_nxt   = 1'b0;
          retx_rem_nxt     = '0;
          to_armed_nxt     = 1'b0;
          to_rem_nxt       = '0;
          lin_armed_nxt    = 1'b0;
          lin_rem_nxt      = '0;
          res.any          = 1'b1;
          res.r0.event_res = sipnict_pkg::EV_TERMINATED;
          res.r0.phase_now = sipnict_pkg::PH_TERMINATED;
        end
      end
      default: begin
      end
    endcase

    res.r0.last = !res.two;
    res.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sipnict_pkg::PH_IDLE;
      retx_rem_r   <= '0;
      retx_int_r   <= '0;
      retx_armed_r <= 1'b0;
      to_rem_r     <= '0;
      to_armed_r   <= 1'b0;
      lin_rem_r    <= '0;
      lin_armed_r  <= 1'b0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      retx_rem_r   <= retx_rem_nxt;
      retx_int_r   <= retx_int_nxt;
      retx_armed_r <= retx_armed_nxt;
      to_rem_r     <= to_rem_nxt;
      to_armed_r   <= to_armed_nxt;
      lin_rem_r    <= lin_rem_nxt;
      lin_armed_r  <= lin_armed_nxt;
    end
  end

endmodule

### rtl/sipnict_outbuf.sv
// ----------------------------------------------------------------------------
// sipnict_outbuf
// Two-entry result buffer; holds the one or two results of the last item.
// ----------------------------------------------------------------------------
module sipnict_outbuf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  sipnict_pkg::res_pair_t res,
  output logic                   ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sipnict_pkg::result_t   out_res
);

  logic                 a_valid_r, b_valid_r;
  sipnict_pkg::result_t a_r, b_r;

  // A new item is taken once the buffer is empty or drains in this cycle.
  assign ready     = !a_valid_r || (out_ready && !b_valid_r);
  assign out_valid = a_valid_r;
  assign out_res   = a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (accept) begin
      a_valid_r <= res.any;
      b_valid_r <= res.two;
    end else if (out_ready && a_valid_r) begin
      a_valid_r <= b_valid_r;
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_r <= res.r0;
      b_r <= res.r1;
    end else if (out_ready && a_valid_r) begin
      a_r <= b_r;
    end
  end

endmodule

### rtl/sip_non_invite_client_transaction.sv
// ----------------------------------------------------------------------------
// sip_non_invite_client_transaction
// Non-INVITE client transaction: send, responses, millisecond ticks, terminate.
// ----------------------------------------------------------------------------
// Results of an accepted item appear on the output in the cycle after it is taken.
// Throughput: one item per cycle while each item gives at most one result and the
//   sink is ready; an item that gives two results holds the input, since the
//   two-entry result buffer must drain before the next item is taken.
// Reset: synchronous, active low; phase idle, all timers disarmed, registers
//   back to T1 = 500, T2 = 4000, T4 = 5000 and an unreliable transport.
// ----------------------------------------------------------------------------
module sip_non_invite_client_transaction (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [9:0] status_code, upper bits zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] event_code, [12:10] phase_now, upper zero
  output logic [1:0]  out_tuser,  // [1:0] event_res
  output logic        out_tlast,  // last result of this input
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  sipnict_pkg::cfg_t      cfg_r;
  sipnict_pkg::res_pair_t res;
  sipnict_pkg::result_t   out_res;
  logic                   accept;

  // Configuration registers. Changes take effect for timers armed afterwards,
  // since the running timers hold their own counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_interval_ms   <= sipnict_pkg::MsW'(500);
      cfg_r.max_interval_ms    <= sipnict_pkg::MsW'(4000);
      cfg_r.linger_ms          <= sipnict_pkg::MsW'(5000);
      cfg_r.reliable_transport <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sipnict_pkg::CFG_BASE_INTERVAL: cfg_r.base_interval_ms   <= cfg_wdata;
        sipnict_pkg::CFG_MAX_INTERVAL:  cfg_r.max_interval_ms    <= cfg_wdata;
        sipnict_pkg::CFG_LINGER:        cfg_r.linger_ms          <= cfg_wdata;
        sipnict_pkg::CFG_RELIABLE:      cfg_r.reliable_transport <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // An item is taken when the result buffer has room for all it may produce.
  assign accept = in_tvalid && in_tready;

  // The transaction logic updates its state and timers on every accepted item
  // and hands zero, one or two results to the buffer in the same edge.
  sipnict_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .op          (in_tuser),
    .status_code (in_tdata[sipnict_pkg::CodeW-1:0]),
    .cfg         (cfg_r),
    .res         (res)
  );

  // The buffer separates the two channels so a waiting result does not stop
  // the next item when the sink takes it in the same cycle.
  sipnict_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .res       (res),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tuser = out_res.event_res;
  assign out_tdata = {3'b000, out_res.phase_now, out_res.event_code};
  assign out_tlast = out_res.last;

endmodule

### rtl/sipnict_checker.sv
// ----------------------------------------------------------------------------
// sipnict_checker
// Port-level checks of the non-INVITE client transaction block.
// ----------------------------------------------------------------------------
module sipnict_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_we,
  input logic [1:0]  cfg_addr,
  input logic [15:0] cfg_wdata
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // Only delivered responses carry a status code.
  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != sipnict_pkg::EV_DELIVER) |-> (out_tdata[9:0] == 10'd0))
    else $error("status code on a non-delivery event");

  // A terminated event always reports the terminated phase.
  a_term_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == sipnict_pkg::EV_TERMINATED) |->
      (out_tdata[12:10] == sipnict_pkg::PH_TERMINATED))
    else $error("terminated event with wrong phase");

  // While the first of two results waits, no new item is taken.
  a_pair_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken while a result pair is pending");

endmodule

bind sip_non_invite_client_transaction sipnict_checker u_sipnict_checker (.*);

### sim/sip_non_invite_client_transaction_tb.sv
// ----------------------------------------------------------------------------
// sip_non_invite_client_transaction_tb
// Self-checking bench for the non-INVITE client transaction block.
// ----------------------------------------------------------------------------
// A queue of requests feeds a clocked driver on the input stream, and a clocked
// monitor takes results off the output stream. Every accepted request runs
// through a behavioral copy of the transaction held here, and the events it
// predicts are compared field by field, in order, with what the block sends.
// The block keeps one transaction from reset to the terminated phase, so the
// run is one long transaction: a short directed opening, long random stretches
// in the proceeding phase with the retransmit cap changed between them, and
// an ending chosen at random (final response with linger, final response on a
// reliable transport, timer F expiry, or an explicit terminate).
// ----------------------------------------------------------------------------
module sip_non_invite_client_transaction_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // One input request as the driver sees it.
  typedef struct packed {
    logic [sipnict_pkg::OpW-1:0]   op;
    logic [sipnict_pkg::CodeW-1:0] code;
  } nict_req_t;

  // How the single transaction of the run comes to an end.
  typedef enum int {
    END_LINGER,
    END_RELIABLE,
    END_TIMEOUT,
    END_ABORT
  } ending_t;

  // Results of an accepted request show up in the cycle after it is taken; the
  // settle margin covers requests that are swallowed without any result.
  localparam int SettleCycles = 4;
  localparam int SegmentCount = 4;
  localparam int SegmentItems = 480;
  localparam int LongHold     = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // [9:0] status_code, upper bits zero
  logic [1:0]  in_tuser = '0;    // [1:0] op

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [9:0] event_code, [12:10] phase_now, upper zero
  logic [1:0]  out_tuser;        // [1:0] event_res
  logic        out_tlast;

  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  // Run control. Both flags are changed with nonblocking assignments so the
  // clocked driver and monitor see them change cleanly at an edge.
  logic calm = 1'b0;       // no idle bursts on either side
  logic rx_hold = 1'b0;    // receiver holds off for a long stretch

  nict_req_t            pending_reqs[$];
  nict_req_t            req_on_bus;
  sipnict_pkg::result_t expected_events[$];
  int                   tx_gap = 0;
  int                   rx_gap = 0;
  int                   errors = 0;
  int                   ticks_since_send = 0;

  // Register copy and transaction state of the predictor.
  sipnict_pkg::cfg_t regs_now = '{base_interval_ms: 16'd500, max_interval_ms: 16'd4000,
                                  linger_ms: 16'd5000, reliable_transport: 1'b0};
  logic [sipnict_pkg::PhaseW-1:0]   txn_phase = sipnict_pkg::PH_IDLE;
  logic [sipnict_pkg::MsW-1:0]      e_left = '0;
  logic [sipnict_pkg::MsW-1:0]      e_period = '0;
  logic                             e_on = 1'b0;
  logic [sipnict_pkg::TimeoutW-1:0] f_left = '0;
  logic                             f_on = 1'b0;
  logic [sipnict_pkg::MsW-1:0]      k_left = '0;
  logic                             k_on = 1'b0;

  sip_non_invite_client_transaction dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Transaction predictor
  // --------------------------------------------------------------------------

  // An event carries the phase the transaction is in right after it.
  function automatic sipnict_pkg::result_t txn_event(
      input logic [sipnict_pkg::EvW-1:0] ev,
      input logic [sipnict_pkg::CodeW-1:0] code);
    sipnict_pkg::result_t r;
    r.event_res  = ev;
    r.event_code = code;
    r.phase_now  = txn_phase;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic void shut_down();
    e_on = 1'b0;
    e_left = '0;
    f_on = 1'b0;
    f_left = '0;
    k_on = 1'b0;
    k_left = '0;
    txn_phase = sipnict_pkg::PH_TERMINATED;
  endfunction

  // Steps the transaction by one accepted request and queues the events that
  // the block has to send for it, the last one flagged.
  function automatic void advance_transaction(input logic [sipnict_pkg::OpW-1:0] op,
                                              input logic [sipnict_pkg::CodeW-1:0] code);
    sipnict_pkg::result_t        evs [2];
    int                          n;
    logic                        live;
    logic                        f_hit;
    logic                        e_hit;
    logic                        k_hit;
    logic [sipnict_pkg::MsW:0]   doubled;
    n = 0;
    live = (txn_phase == sipnict_pkg::PH_TRYING) ||
           (txn_phase == sipnict_pkg::PH_PROCEEDING);
    case (op)
      sipnict_pkg::OP_SEND: begin
        // A second send is ignored once the transaction has left idle.
        if (txn_phase == sipnict_pkg::PH_IDLE) begin
          txn_phase = sipnict_pkg::PH_TRYING;
          f_left = sipnict_pkg::TimeoutW'(regs_now.base_interval_ms *
                                          sipnict_pkg::TIMEOUT_MULTIPLE);
          f_on = 1'b1;
          if (!regs_now.reliable_transport) begin
            e_period = regs_now.base_interval_ms;
            e_left = regs_now.base_interval_ms;
            e_on = 1'b1;
          end
          evs[n] = txn_event(sipnict_pkg::EV_TRANSMIT, '0);
          n++;
        end
      end
      sipnict_pkg::OP_RESPONSE: begin
        if (live) begin
          if (code < sipnict_pkg::FINAL_CODE_MIN) begin
            // Provisional, including codes under 100.
            txn_phase = sipnict_pkg::PH_PROCEEDING;
            evs[n] = txn_event(sipnict_pkg::EV_DELIVER, code);
            n++;
          end else begin
            txn_phase = sipnict_pkg::PH_COMPLETED;
            e_on = 1'b0;
            e_left = '0;
            f_on = 1'b0;
            f_left = '0;
            evs[n] = txn_event(sipnict_pkg::EV_DELIVER, code);
            n++;
            if (!regs_now.reliable_transport) begin
              k_left = regs_now.linger_ms;
              k_on = 1'b1;
            end else begin
              shut_down();
              evs[n] = txn_event(sipnict_pkg::EV_TERMINATED, '0);
              n++;
            end
          end
        end
      end
      sipnict_pkg::OP_TICK: begin
        // All armed timers count down on every tick, whatever the phase.
        f_hit = f_on && (f_left <= 1);
        if (f_on) f_left = f_hit ? '0 : f_left - 1'b1;
        e_hit = e_on && (e_left <= 1);
        if (e_on) e_left = e_hit ? '0 : e_left - 1'b1;
        k_hit = k_on && (k_left <= 1);
        if (k_on) k_left = k_hit ? '0 : k_left - 1'b1;
        // Timer F wins over a retransmit due on the same tick.
        if (f_hit && live) begin
          evs[n] = txn_event(sipnict_pkg::EV_TIMEOUT, '0);
          n++;
          shut_down();
          evs[n] = txn_event(sipnict_pkg::EV_TERMINATED, '0);
          n++;
        end else if (e_hit && live) begin
          if (txn_phase == sipnict_pkg::PH_TRYING) begin
            doubled = {e_period, 1'b0};
            e_period = (doubled < {1'b0, regs_now.max_interval_ms}) ?
                       doubled[sipnict_pkg::MsW-1:0] : regs_now.max_interval_ms;
          end else begin
            e_period = regs_now.max_interval_ms;
          end
          e_left = e_period;
          evs[n] = txn_event(sipnict_pkg::EV_TRANSMIT, '0);
          n++;
        end else if (k_hit && txn_phase == sipnict_pkg::PH_COMPLETED) begin
          shut_down();
          evs[n] = txn_event(sipnict_pkg::EV_TERMINATED, '0);
          n++;
        end
      end
      default: begin
        if (txn_phase != sipnict_pkg::PH_TERMINATED) begin
          shut_down();
          evs[n] = txn_event(sipnict_pkg::EV_TERMINATED, '0);
          n++;
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) evs[i].last = 1'b1;
      expected_events.push_back(evs[i]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued requests, with random idle bursts unless calm.
  // The predictor runs at the edge where a request is accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : feed_requests
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_transaction(req_on_bus.op, req_on_bus.code);
      end
      // Only move on once the current request is gone or none is offered.
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          // Start an idle burst, this cycle included.
          tx_gap = $urandom_range(0, 11);
          in_tvalid <= 1'b0;
        end else begin
          req_on_bus = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= 16'(req_on_bus.code);
          in_tuser <= req_on_bus.op;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest expected event.
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input sipnict_pkg::result_t want,
                               input sipnict_pkg::result_t got,
                               input bit orphan);
    errors++;
    if (errors <= 10) begin
      if (orphan) begin
        $display("unexpected result: ev=%0d code=%0d phase=%0d last=%0b",
                 got.event_res, got.event_code, got.phase_now, got.last);
      end else begin
        $display({"result mismatch: expected ev=%0d code=%0d phase=%0d last=%0b,",
                  " got ev=%0d code=%0d phase=%0d last=%0b"},
                 want.event_res, want.event_code, want.phase_now, want.last,
                 got.event_res, got.event_code, got.phase_now, got.last);
      end
    end
  endtask

  always @(posedge clk) begin : watch_results
    sipnict_pkg::result_t got;
    sipnict_pkg::result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.event_res  = out_tuser;
        got.event_code = out_tdata[sipnict_pkg::CodeW-1:0];
        got.phase_now  = out_tdata[sipnict_pkg::CodeW +: sipnict_pkg::PhaseW];
        got.last       = out_tlast;
        if (expected_events.size() == 0) begin
          note_mismatch(got, got, 1'b1);
        end else begin
          want = expected_events.pop_front();
          if (got.event_res !== want.event_res || got.event_code !== want.event_code ||
              got.phase_now !== want.phase_now || got.last !== want.last) begin
            note_mismatch(want, got, 1'b0);
          end
        end
      end
      if (rx_hold) begin
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        rx_gap = $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_req(input logic [sipnict_pkg::OpW-1:0] op,
                           input logic [sipnict_pkg::CodeW-1:0] code);
    nict_req_t r;
    r.op = op;
    r.code = code;
    pending_reqs.push_back(r);
    // Timer F only counts ticks after the send, so the budget starts there.
    if (op == sipnict_pkg::OP_TICK) ticks_since_send++;
  endtask

  function automatic logic [sipnict_pkg::CodeW-1:0] provisional_code();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return sipnict_pkg::CodeW'(100);
    if (pick == 1) return sipnict_pkg::FINAL_CODE_MIN - 1'b1;
    if (pick < 4) return sipnict_pkg::CodeW'($urandom_range(0, 99));
    return sipnict_pkg::CodeW'($urandom_range(100, 199));
  endfunction

  // Waits until every queued request is taken and every expected event has
  // come back, then lets the block finish any swallowed request.
  task automatic settle(input int extra);
    @(negedge clk);
    while (pending_reqs.size() != 0 || in_tvalid || expected_events.size() != 0) begin
      @(negedge clk);
    end
    repeat (extra) @(posedge clk);
  endtask

  // Register writes are issued back to back, one per cycle; the predictor's
  // copy is updated at once since nothing is in flight.
  task automatic write_reg(input logic [sipnict_pkg::CfgAddrW-1:0] idx,
                           input logic [sipnict_pkg::MsW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      sipnict_pkg::CFG_BASE_INTERVAL: regs_now.base_interval_ms = val;
      sipnict_pkg::CFG_MAX_INTERVAL:  regs_now.max_interval_ms = val;
      sipnict_pkg::CFG_LINGER:        regs_now.linger_ms = val;
      sipnict_pkg::CFG_RELIABLE:      regs_now.reliable_transport = val[0];
      default: begin
      end
    endcase
  endtask

  task automatic close_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : run_stimulus
    int          t1;
    int          t2;
    int          first_reload;
    int          f_len;
    int          allot;
    int          counted;
    int          seg_ticks;
    logic [15:0] linger;
    logic [9:0]  closing_code;
    ending_t     ending;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Idle: a tick and two responses are all swallowed without a result.
    queue_req(sipnict_pkg::OP_TICK, '0);
    queue_req(sipnict_pkg::OP_RESPONSE, sipnict_pkg::FINAL_CODE_MIN);
    queue_req(sipnict_pkg::OP_RESPONSE, sipnict_pkg::CodeW'(150));
    settle(SettleCycles);

    // Pass through the top of every register before the working setting.
    // T1 is kept small so that retransmits come early; T2 sometimes caps the
    // first doubling and sometimes does not.
    t1 = $urandom_range(3, 6);
    t2 = $urandom_range(t1 + 1, 2 * t1 + 3);
    first_reload = (2 * t1 < t2) ? 2 * t1 : t2;
    f_len = sipnict_pkg::TIMEOUT_MULTIPLE * t1;
    write_reg(sipnict_pkg::CFG_BASE_INTERVAL, 16'hFFFF);
    write_reg(sipnict_pkg::CFG_MAX_INTERVAL, 16'hFFFF);
    write_reg(sipnict_pkg::CFG_LINGER, 16'hFFFF);
    write_reg(sipnict_pkg::CFG_RELIABLE, 16'd1);
    write_reg(sipnict_pkg::CFG_BASE_INTERVAL, sipnict_pkg::MsW'(t1));
    write_reg(sipnict_pkg::CFG_MAX_INTERVAL, sipnict_pkg::MsW'(t2));
    write_reg(sipnict_pkg::CFG_LINGER, '0);
    write_reg(sipnict_pkg::CFG_RELIABLE, '0);
    close_writes();

    // Directed opening: send, a repeated send that is ignored, the first
    // retransmit in trying with its doubled interval, provisional responses
    // (including codes under 100), then a retransmit in proceeding at T2.
    ticks_since_send = 0;
    queue_req(sipnict_pkg::OP_SEND, '0);
    queue_req(sipnict_pkg::OP_SEND, sipnict_pkg::CodeW'(699));
    repeat (t1) queue_req(sipnict_pkg::OP_TICK, '0);
    queue_req(sipnict_pkg::OP_RESPONSE, sipnict_pkg::CodeW'(100));
    queue_req(sipnict_pkg::OP_RESPONSE, '0);
    queue_req(sipnict_pkg::OP_RESPONSE, sipnict_pkg::CodeW'(99));
    queue_req(sipnict_pkg::OP_RESPONSE, sipnict_pkg::FINAL_CODE_MIN - 1'b1);
    queue_req(sipnict_pkg::OP_SEND, '0);
    repeat (first_reload) queue_req(sipnict_pkg::OP_TICK, '0);
    settle(SettleCycles);

    // Random stretches in proceeding. Ticks are spread over the stretches so
    // that timer F never runs out before the ending; sends are noise.
    for (int seg = 0; seg < SegmentCount; seg++) begin
      write_reg(sipnict_pkg::CFG_MAX_INTERVAL,
                (seg == 0) ? sipnict_pkg::MsW'(1) : sipnict_pkg::MsW'($urandom_range(2, 16)));
      if (seg == 1) write_reg(sipnict_pkg::CFG_BASE_INTERVAL, sipnict_pkg::MsW'(1));
      if (seg == 2) write_reg(sipnict_pkg::CFG_LINGER, sipnict_pkg::MsW'($urandom_range(0, 40)));
      write_reg(sipnict_pkg::CFG_RELIABLE, sipnict_pkg::MsW'($urandom_range(0, 1)));
      close_writes();
      calm <= (seg == SegmentCount - 1);

      allot = (f_len - 24 - ticks_since_send) / (SegmentCount - seg);
      counted = 0;
      seg_ticks = 0;
      while (counted < SegmentItems) begin
        if ($urandom_range(0, 99) < 12) begin
          queue_req(sipnict_pkg::OP_SEND, sipnict_pkg::CodeW'($urandom_range(0, 1023)));
        end else if (seg_ticks < allot && $urandom_range(0, SegmentItems - 1) < allot) begin
          queue_req(sipnict_pkg::OP_TICK, sipnict_pkg::CodeW'($urandom_range(0, 1023)));
          seg_ticks++;
        end else begin
          queue_req(sipnict_pkg::OP_RESPONSE, provisional_code());
        end
        counted++;
      end

      // In the second stretch the receiver stops for a long while, so the
      // result buffer fills and the block pushes back on the driver.
      if (seg == 1) begin
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (LongHold) @(posedge clk);
        rx_hold <= 1'b0;
      end
      settle(SettleCycles);
    end

    // Ending of the transaction.
    ending = ending_t'($urandom_range(0, 3));
    case ($urandom_range(0, 2))
      0:       closing_code = sipnict_pkg::FINAL_CODE_MIN;
      1:       closing_code = sipnict_pkg::CodeW'(699);
      default: closing_code = sipnict_pkg::CodeW'($urandom_range(200, 699));
    endcase
    case (ending)
      END_TIMEOUT: begin
        // With T2 at one, timer E is due on the same tick as timer F.
        write_reg(sipnict_pkg::CFG_MAX_INTERVAL, sipnict_pkg::MsW'(1));
        close_writes();
        while (ticks_since_send < f_len) begin
          if ($urandom_range(0, 2) == 0) begin
            queue_req(sipnict_pkg::OP_RESPONSE, provisional_code());
          end
          queue_req(sipnict_pkg::OP_TICK, '0);
        end
      end
      END_LINGER: begin
        case ($urandom_range(0, 2))
          0:       linger = '0;
          1:       linger = 16'hFFFF;
          default: linger = sipnict_pkg::MsW'($urandom_range(1, 20));
        endcase
        write_reg(sipnict_pkg::CFG_MAX_INTERVAL, 16'hFFFF);
        write_reg(sipnict_pkg::CFG_LINGER, linger);
        write_reg(sipnict_pkg::CFG_RELIABLE, '0);
        close_writes();
        queue_req(sipnict_pkg::OP_RESPONSE, closing_code);
        // Completed ignores further responses and sends.
        queue_req(sipnict_pkg::OP_RESPONSE, provisional_code());
        queue_req(sipnict_pkg::OP_SEND, '0);
        if (linger == 16'hFFFF) begin
          repeat (10) queue_req(sipnict_pkg::OP_TICK, '0);
          queue_req(sipnict_pkg::OP_TERMINATE, '0);
        end else begin
          repeat (int'(linger) + 3) queue_req(sipnict_pkg::OP_TICK, '0);
        end
      end
      END_RELIABLE: begin
        write_reg(sipnict_pkg::CFG_MAX_INTERVAL, 16'hFFFF);
        write_reg(sipnict_pkg::CFG_LINGER, sipnict_pkg::MsW'($urandom_range(0, 65535)));
        write_reg(sipnict_pkg::CFG_RELIABLE, sipnict_pkg::MsW'(1));
        close_writes();
        queue_req(sipnict_pkg::OP_RESPONSE, closing_code);
      end
      default: begin
        write_reg(sipnict_pkg::CFG_LINGER, sipnict_pkg::MsW'($urandom_range(0, 65535)));
        close_writes();
        queue_req(sipnict_pkg::OP_TERMINATE, '0);
      end
    endcase

    // Terminated is final: nothing below may cause a result.
    queue_req(sipnict_pkg::OP_TICK, '0);
    queue_req(sipnict_pkg::OP_RESPONSE, sipnict_pkg::FINAL_CODE_MIN);
    queue_req(sipnict_pkg::OP_SEND, '0);
    queue_req(sipnict_pkg::OP_TERMINATE, '0);
    settle(SettleCycles);

    if (errors == 0 && expected_events.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
